FILE: sv/twbs_pkg.sv
// Shared types, codes and field widths of the texture wrap bilinear sampler.
package twbs_pkg;

    localparam int COORD_W   = 24;
    localparam int BYTE_W    = 8;
    localparam int TEXEL_W   = 3 * BYTE_W;
    localparam int SZ_W      = 9;
    localparam int IN_DATA_W = 2 * COORD_W + 5 * BYTE_W;
    localparam int OUT_DATA_W = TEXEL_W;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [2:0] CFG_WRAP   = 3'd0;
    localparam logic [2:0] CFG_FILTER = 3'd1;
    localparam logic [2:0] CFG_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_CHAN   = 3'd4;

    localparam logic [1:0] WRAP_REPEAT = 2'd0;
    localparam logic [1:0] WRAP_CLAMP  = 2'd1;

    localparam logic FILT_NEAREST = 1'b0;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic [1:0] CH_GREY = 2'd1;
    localparam logic [1:0] CH_RGB  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_U,
        ST_MUL_V,
        ST_FETCH,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

FILE: sv/twbs_texmem.sv
// Single-port texel memory with registered read data.
module twbs_texmem #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [ADDR_W-1:0]              i_addr,
    input  logic [twbs_pkg::TEXEL_W-1:0]   i_wdata,
    output logic [twbs_pkg::TEXEL_W-1:0]   o_rdata
);
    import twbs_pkg::*;

    logic [TEXEL_W-1:0] r_mem [DEPTH];
    logic [TEXEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/texture_wrap_bilinear_sampler.sv
// Top level of the texture sampler: config registers, sequencer and blend datapath.
//
//  channel   | dir | handshake                     | word contents
//  ----------+-----+-------------------------------+------------------------------------
//  s_axis    | in  | tvalid/tready                 | tuser func; tdata u,v,x,y,r,g,b
//  m_axis    | out | tvalid/tready                 | tdata red, green, blue
//  apb       | in  | psel/penable/pwrite, pready=1 | five config registers at 4*i
//
//  A load word is written to the texel memory at the edge it is accepted.
//  A sample word steps the sequencer through mul_u, mul_v, fetch, drain and done before it
//  is back in idle: two passes of the shared multiplier scale u and v, then one pass per
//  texel fetched from the single-ported memory computes that corner's weight.
//  The result sits in an output register, so the next word is accepted while it waits;
//  only a second finished result waits in the done state for m_axis_tready.
//  Reset is synchronous, active low; it clears control state and loads the register
//  defaults. The texel memory is not cleared.
module texture_wrap_bilinear_sampler #(
    parameter int MAX_DIM   = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // u_coord, v_coord, load_x, load_y, load_red, load_green, load_blue (low bit up)
    input  logic [twbs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // func
    input  logic [0:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_red, out_green, out_blue (low bit up)
    output logic [twbs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [twbs_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [twbs_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [twbs_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import twbs_pkg::*;

    localparam int F      = FRAC_BITS;
    localparam int ONE_W  = F + 1;
    localparam int STW    = F + 1 + SZ_W;
    localparam int PW     = 2 * ONE_W;
    localparam int WW     = 2 * F + 1;
    localparam int ACCW   = 2 * F + BYTE_W;
    localparam int CEW    = (F + 2 > COORD_W) ? F + 2 : COORD_W;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = $clog2(DEPTH);
    localparam int SZ_CAP = (MAX_DIM > 512) ? 511 : MAX_DIM - 1;

    localparam logic [ONE_W-1:0]      ONE_C  = ONE_W'(1) << F;
    localparam logic signed [CEW-1:0] ONE_S  = CEW'(ONE_C);
    localparam logic [STW:0]          HALF_C = (STW + 1)'(1) << (F - 1);
    localparam logic [ACCW-1:0]       RND_C  = ACCW'(1) << (2 * F - 1);
    localparam logic [AW-1:0]         DIM_A  = AW'(MAX_DIM);

    // ---------------------------------------------------------------- helpers
    function automatic logic [ONE_W-1:0] wrap_coord(input logic [COORD_W-1:0] c,
                                                     input logic [1:0] mode);
        logic signed [CEW-1:0] ce;
        logic [ONE_W-1:0]      s;
        ce = CEW'($signed(c));
        case (mode)
            WRAP_REPEAT: begin
                s = (ce[F-1:0] == '0) ? ONE_C : {1'b0, ce[F-1:0]};
            end
            WRAP_CLAMP: begin
                if (ce < 0) s = '0;
                else if (ce > ONE_S) s = ONE_C;
                else s = ce[F:0];
            end
            default: begin
                if (ce < 0 || ce > ONE_S) s = '0;
                else s = ce[F:0];
            end
        endcase
        return s;
    endfunction

    // size minus one, with zero acting as one and oversize capped at the store
    function automatic logic [SZ_W-1:0] size_m1(input logic [SZ_W-1:0] sz);
        logic [SZ_W-1:0] r;
        if (sz == '0) r = '0;
        else if ({23'd0, sz} > 32'(MAX_DIM)) r = SZ_W'(SZ_CAP);
        else r = sz - SZ_W'(1);
        return r;
    endfunction

    // ---------------------------------------------------------------- unpack
    logic              in_func;
    logic [COORD_W-1:0] in_u, in_v;
    logic [BYTE_W-1:0] in_x, in_y, in_red, in_green, in_blue;

    assign in_func  = s_axis_tuser[0];
    assign in_u     = s_axis_tdata[0 +: COORD_W];
    assign in_v     = s_axis_tdata[COORD_W +: COORD_W];
    assign in_x     = s_axis_tdata[2*COORD_W +: BYTE_W];
    assign in_y     = s_axis_tdata[2*COORD_W + BYTE_W +: BYTE_W];
    assign in_red   = s_axis_tdata[2*COORD_W + 2*BYTE_W +: BYTE_W];
    assign in_green = s_axis_tdata[2*COORD_W + 3*BYTE_W +: BYTE_W];
    assign in_blue  = s_axis_tdata[2*COORD_W + 4*BYTE_W +: BYTE_W];

    // ---------------------------------------------------------------- config
    logic [1:0]      r_wrap;
    logic            r_filter;
    logic [SZ_W-1:0] r_width, r_height;
    logic [1:0]      r_chan;
    logic            cfg_we;
    logic [2:0]      cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap   <= WRAP_REPEAT;
            r_filter <= FILT_NEAREST;
            r_width  <= SZ_W'(256);
            r_height <= SZ_W'(256);
            r_chan   <= CH_RGB;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_WRAP:   r_wrap   <= pwdata[1:0];
                CFG_FILTER: r_filter <= pwdata[0];
                CFG_WIDTH:  r_width  <= pwdata[SZ_W-1:0];
                CFG_HEIGHT: r_height <= pwdata[SZ_W-1:0];
                CFG_CHAN:   r_chan   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            CFG_WRAP:   prdata = CFG_DATA_W'(r_wrap);
            CFG_FILTER: prdata = CFG_DATA_W'(r_filter);
            CFG_WIDTH:  prdata = CFG_DATA_W'(r_width);
            CFG_HEIGHT: prdata = CFG_DATA_W'(r_height);
            CFG_CHAN:   prdata = CFG_DATA_W'(r_chan);
            default:    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- sequencer
    t_state r_state, n_state;
    logic   in_fire, out_load, last_fetch, nearest;

    logic [1:0] r_corner;
    logic       r_mac;
    logic       r_m_valid;

    assign nearest    = (r_filter == FILT_NEAREST);
    assign in_fire    = s_axis_tvalid & s_axis_tready;
    assign last_fetch = nearest || (r_corner == 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && in_func == FUNC_SAMPLE) n_state = ST_MUL_U;
            end
            ST_MUL_U: n_state = ST_MUL_V;
            ST_MUL_V: n_state = ST_FETCH;
            ST_FETCH: begin
                if (last_fetch) n_state = ST_DRAIN;
            end
            ST_DRAIN: n_state = ST_DONE;
            ST_DONE: begin
                // hold until the output register is free
                if (!r_m_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- shared multiplier
    logic [COORD_W-1:0] r_u, r_v;
    logic [STW-1:0]     r_st_u, r_st_v;
    logic [F-1:0]       fx, fy;
    logic [ONE_W-1:0]   mul_a, mul_b;
    logic [PW-1:0]      prod;

    assign fx = r_st_u[F-1:0];
    assign fy = r_st_v[F-1:0];

    always_comb begin
        mul_a = ONE_C;
        mul_b = ONE_C;
        case (r_state)
            ST_MUL_U: begin
                mul_a = wrap_coord(r_u, r_wrap);
                mul_b = ONE_W'(size_m1(r_width));
            end
            ST_MUL_V: begin
                mul_a = wrap_coord(r_v, r_wrap);
                mul_b = ONE_W'(size_m1(r_height));
            end
            ST_FETCH: begin
                // corner weight; nearest takes full weight on its one texel
                if (!nearest) begin
                    mul_a = r_corner[0] ? {1'b0, fx} : ONE_C - {1'b0, fx};
                    mul_b = r_corner[1] ? {1'b0, fy} : ONE_C - {1'b0, fy};
                end
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    // ---------------------------------------------------------------- texel address
    logic [STW:0]     sum_u, sum_v;
    logic [SZ_W-1:0]  x0, y0, x1, y1, tx, ty;
    logic [AW-1:0]    rd_addr, ld_addr, mem_addr;
    logic             ld_ok, mem_we;
    logic [TEXEL_W-1:0] mem_rdata;

    assign sum_u = {1'b0, r_st_u} + HALF_C;
    assign sum_v = {1'b0, r_st_v} + HALF_C;
    assign x0    = r_st_u[F +: SZ_W];
    assign y0    = r_st_v[F +: SZ_W];
    assign x1    = x0 + SZ_W'(fx != '0);
    assign y1    = y0 + SZ_W'(fy != '0);

    always_comb begin
        if (nearest) begin
            tx = sum_u[F +: SZ_W];
            ty = sum_v[F +: SZ_W];
        end else begin
            tx = r_corner[0] ? x1 : x0;
            ty = r_corner[1] ? y1 : y0;
        end
    end

    assign rd_addr  = AW'(ty) * DIM_A + AW'(tx);
    assign ld_addr  = AW'(in_y) * DIM_A + AW'(in_x);
    assign ld_ok    = ({24'd0, in_x} < 32'(MAX_DIM)) && ({24'd0, in_y} < 32'(MAX_DIM));
    assign mem_we   = in_fire && (in_func == FUNC_LOAD) && ld_ok;
    assign mem_addr = (r_state == ST_IDLE) ? ld_addr : rd_addr;

    twbs_texmem #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_texmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata ({in_blue, in_green, in_red}),
        .o_rdata (mem_rdata)
    );

    // ---------------------------------------------------------------- blend
    logic [WW-1:0]     r_w;
    logic [ACCW-1:0]   r_acc [3];
    logic [BYTE_W-1:0] pix [3];
    logic [ACCW-1:0]   rnd [3];
    logic [OUT_DATA_W-1:0] res;
    logic [OUT_DATA_W-1:0] r_m_data;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            // grey images replicate red
            pix[ch] = (r_chan == CH_GREY) ? mem_rdata[0 +: BYTE_W]
                                          : mem_rdata[BYTE_W*ch +: BYTE_W];
            rnd[ch] = r_acc[ch] + RND_C;
            res[BYTE_W*ch +: BYTE_W] = rnd[ch][2*F +: BYTE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_u <= in_u;
            r_v <= in_v;
        end
        if (r_state == ST_MUL_U) r_st_u <= prod[STW-1:0];
        if (r_state == ST_MUL_V) begin
            r_st_v <= prod[STW-1:0];
            for (int ch = 0; ch < 3; ch++) r_acc[ch] <= '0;
        end else if (r_mac) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_acc[ch] <= r_acc[ch] + ACCW'(r_w) * ACCW'(pix[ch]);
            end
        end
        if (r_state == ST_FETCH) r_w <= prod[WW-1:0];
        if (out_load) r_m_data <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner  <= '0;
            r_mac     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            // advance the corner while fetching, restart it for each sample
            if (r_state == ST_FETCH) r_corner <= r_corner + 2'd1;
            else r_corner <= '0;
            r_mac <= (r_state == ST_FETCH);
            if (out_load) r_m_valid <= 1'b1;
            else if (m_axis_tready) r_m_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

FILE: test/texture_wrap_bilinear_sampler_tb.sv
// Self-checking testbench: directed script then randomized load/sample traffic with a predictor.
module texture_wrap_bilinear_sampler_tb;
    import twbs_pkg::*;

    localparam int MAX_DIM   = 256;
    localparam int FRAC_BITS = 16;
    localparam longint ONE_FX  = longint'(1) << FRAC_BITS;
    localparam longint HALF_FX = ONE_FX >> 1;
    localparam longint ROUND_BLEND = longint'(1) << (2 * FRAC_BITS - 1);

    // The slowest sample is bilinear, and a 70% stall run on either side can stretch it;
    // allow far more quiet time than that before declaring the block hung.
    localparam int QUIET_LIMIT   = 2000;
    // Pause after the last result so a trailing texel write has landed.
    localparam int SETTLE_CYCLES = 12;
    localparam int SEG_ITEMS     = 125;
    localparam int SEG_COUNT     = 12;
    localparam int REPORT_CAP    = 100;

    // Codes the package does not name.
    localparam logic [1:0] WRAP_ZERO     = 2'd2;
    localparam logic [1:0] WRAP_SPARE    = 2'd3;
    localparam logic       FILT_BILINEAR = 1'b1;
    localparam logic [1:0] CH_CODE0      = 2'd0;
    localparam logic [1:0] CH_CODE2      = 2'd2;

    // One input word, u_coord in the low bits.
    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  y;
        logic [7:0]  x;
        logic [23:0] v;
        logic [23:0] u;
    } t_in_word;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_LOAD,
        ROW_SAMPLE
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [2:0]  reg_idx;
        logic [31:0] value;
        t_in_word    word;
        logic        typed;
        logic [23:0] rgb;
    } t_script_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // u_coord, v_coord, load_x, load_y, load_red, load_green, load_blue (low bit up)
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // func
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // out_red, out_green, out_blue (low bit up)
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Mirror of the configuration registers.
    logic [1:0] wrap_q   = WRAP_REPEAT;
    logic       filt_q   = FILT_NEAREST;
    logic [8:0] width_q  = 9'd256;
    logic [8:0] height_q = 9'd256;
    logic [1:0] chan_q   = CH_RGB;

    // Mirror of the texel memory; only loaded entries are ever sampled.
    logic [23:0] texel_mirror [0:MAX_DIM*MAX_DIM-1];
    bit          texel_loaded [0:MAX_DIM*MAX_DIM-1];

    logic [23:0] rgb_pending [$];
    t_script_row script [$];

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          items_sent     = 0;
    int          mismatches     = 0;
    int          quiet_cycles   = 0;
    logic [23:0] want_rgb;

    texture_wrap_bilinear_sampler #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    // Size registers: zero acts as one, anything past the store acts as the store size.
    function automatic longint eff_dim(input logic [8:0] dim);
        if (dim == 9'd0) return 1;
        if (int'(dim) > MAX_DIM) return MAX_DIM;
        return longint'(dim);
    endfunction

    // Fold one signed Q8.16 coordinate into [0, ONE] per the current wrap mode.
    function automatic longint wrap_axis(input logic [23:0] coord);
        longint c;
        c = longint'(signed'(coord));
        case (wrap_q)
            WRAP_REPEAT: begin
                // exact integers land on 1.0, not 0.0
                if (coord[FRAC_BITS-1:0] == '0) return ONE_FX;
                return longint'(coord[FRAC_BITS-1:0]);
            end
            WRAP_CLAMP: begin
                if (c < 0) return 0;
                if (c > ONE_FX) return ONE_FX;
                return c;
            end
            default: begin
                // zero mode, and the spare code behaves the same
                if (c < 0 || c > ONE_FX) return 0;
                return c;
            end
        endcase
    endfunction

    // Texel corners and blend fractions of one sample. Nearest mode collapses to a
    // single corner with zero fractions, so the blend below reproduces that texel.
    function automatic void find_corners(input logic [23:0] u, input logic [23:0] v,
                                         output int xa, output int xb,
                                         output int ya, output int yb,
                                         output longint fx, output longint fy);
        longint su;
        longint sv;
        su = wrap_axis(u) * (eff_dim(width_q) - 1);
        sv = wrap_axis(v) * (eff_dim(height_q) - 1);
        if (filt_q == FILT_NEAREST) begin
            xa = int'((su + HALF_FX) >> FRAC_BITS);
            ya = int'((sv + HALF_FX) >> FRAC_BITS);
            xb = xa;
            yb = ya;
            fx = 0;
            fy = 0;
        end else begin
            xa = int'(su >> FRAC_BITS);
            ya = int'(sv >> FRAC_BITS);
            fx = su & (ONE_FX - 1);
            fy = sv & (ONE_FX - 1);
            xb = (fx != 0) ? xa + 1 : xa;
            yb = (fy != 0) ? ya + 1 : ya;
        end
    endfunction

    function automatic longint texel_byte(input int x, input int y, input int ch);
        logic [23:0] t;
        int          sel;
        t   = texel_mirror[y * MAX_DIM + x];
        // grey images replicate red into all three outputs
        sel = (chan_q == CH_GREY) ? 0 : ch;
        return longint'(t[8*sel +: 8]);
    endfunction

    function automatic logic [23:0] filtered_rgb(input logic [23:0] u, input logic [23:0] v);
        int          xa, xb, ya, yb;
        longint      fx, fy, top, bot, acc;
        logic [23:0] rgb;
        find_corners(u, v, xa, xb, ya, yb, fx, fy);
        for (int ch = 0; ch < 3; ch++) begin
            top = (ONE_FX - fx) * texel_byte(xa, ya, ch) + fx * texel_byte(xb, ya, ch);
            bot = (ONE_FX - fx) * texel_byte(xa, yb, ch) + fx * texel_byte(xb, yb, ch);
            acc = (ONE_FX - fy) * top + fy * bot;
            rgb[8*ch +: 8] = 8'((acc + ROUND_BLEND) >> (2 * FRAC_BITS));
        end
        return rgb;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic t_in_word random_word();
        t_in_word w;
        w.u     = 24'($urandom);
        w.v     = 24'($urandom);
        w.x     = 8'($urandom);
        w.y     = 8'($urandom);
        w.red   = 8'($urandom);
        w.green = 8'($urandom);
        w.blue  = 8'($urandom);
        return w;
    endfunction

    // Mix of wild values, exact integers, half-way points, edges and the unit range.
    function automatic logic [23:0] rand_coord();
        case ($urandom_range(5, 0))
            0: return 24'($urandom);
            1: return {8'($urandom), 16'h0000};
            2: return {8'($urandom), 16'h8000};
            3: begin
                case ($urandom_range(3, 0))
                    0: return 24'h000000;
                    1: return 24'h010000;
                    2: return 24'hffffff;
                    default: return 24'h010001;
                endcase
            end
            default: return 24'($urandom_range(int'(ONE_FX), 0));
        endcase
    endfunction

    // Mostly small textures, sometimes the full store or out-of-range size codes.
    function automatic logic [8:0] pick_dim();
        case ($urandom_range(9, 0))
            0: return 9'd1;
            1: return 9'd256;
            2: return 9'd0;
            3: return 9'($urandom_range(511, 257));
            4: return 9'd2;
            default: return 9'($urandom_range(16, 1));
        endcase
    endfunction

    function automatic t_script_row cfg_row(input logic [2:0] idx, input logic [31:0] value);
        t_script_row row;
        row         = '0;
        row.kind    = ROW_CFG;
        row.reg_idx = idx;
        row.value   = value;
        return row;
    endfunction

    function automatic t_script_row load_row(input logic [7:0] x, input logic [7:0] y,
                                             input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
        t_script_row row;
        row            = '0;
        row.kind       = ROW_LOAD;
        row.word       = random_word();
        row.word.x     = x;
        row.word.y     = y;
        row.word.red   = r;
        row.word.green = g;
        row.word.blue  = b;
        return row;
    endfunction

    function automatic t_script_row probe_row(input logic [23:0] u, input logic [23:0] v,
                                              input logic typed, input logic [23:0] rgb);
        t_script_row row;
        row        = '0;
        row.kind   = ROW_SAMPLE;
        row.word   = random_word();
        row.word.u = u;
        row.word.v = v;
        row.typed  = typed;
        row.rgb    = rgb;
        return row;
    endfunction

    // ---------------------------------------------------------------- bus tasks

    // Present one word, hold it until accepted, then update the mirrors.
    // Enter and leave at a falling edge.
    task automatic send_word(input logic func, input t_in_word w,
                             input logic typed, input logic [23:0] typed_rgb);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= func;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (func == FUNC_LOAD) begin
            texel_mirror[int'(w.y) * MAX_DIM + int'(w.x)] = {w.blue, w.green, w.red};
            texel_loaded[int'(w.y) * MAX_DIM + int'(w.x)] = 1'b1;
        end else if (typed) begin
            rgb_pending.push_back(typed_rgb);
        end else begin
            rgb_pending.push_back(filtered_rgb(w.u, w.v));
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_if_blank(input int x, input int y);
        t_in_word w;
        if (!texel_loaded[y * MAX_DIM + x]) begin
            w   = random_word();
            w.x = 8'(x);
            w.y = 8'(y);
            send_word(FUNC_LOAD, w, 1'b0, '0);
        end
    endtask

    // Load any corner that a sample would read before it was ever written.
    task automatic fill_corners(input logic [23:0] u, input logic [23:0] v);
        int     xa, xb, ya, yb;
        longint fx, fy;
        find_corners(u, v, xa, xb, ya, yb, fx, fy);
        load_if_blank(xa, ya);
        load_if_blank(xb, ya);
        load_if_blank(xa, yb);
        load_if_blank(xb, yb);
    endtask

    // Drop valid, drain every pending result, then give a trailing load time to land.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (rgb_pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the access edge.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            CFG_WRAP:   wrap_q   = value[1:0];
            CFG_FILTER: filt_q   = value[0];
            CFG_WIDTH:  width_q  = value[8:0];
            CFG_HEIGHT: height_q = value[8:0];
            CFG_CHAN:   chan_q   = value[1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    // ---------------------------------------------------------------- result side

    // Stall the result side at random per the current phase.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // Compare each result word, byte by byte, with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (rgb_pending.size() == 0) begin
                report_mismatch("result with nothing pending", m_axis_tdata, '0);
            end else begin
                want_rgb = rgb_pending.pop_front();
                if (m_axis_tdata[7:0] !== want_rgb[7:0])
                    report_mismatch("out_red", m_axis_tdata, want_rgb);
                if (m_axis_tdata[15:8] !== want_rgb[15:8])
                    report_mismatch("out_green", m_axis_tdata, want_rgb);
                if (m_axis_tdata[23:16] !== want_rgb[23:16])
                    report_mismatch("out_blue", m_axis_tdata, want_rgb);
            end
        end
    end

    // Watchdog: any stream handshake or register write counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        t_in_word   w;
        int         seg_start;
        int         phase;
        logic [8:0] dim_w, dim_h;

        // Directed script. Colors pack as {blue, green, red}.
        // Defaults after reset: repeat, nearest, 256 x 256, rgb.
        script.push_back(load_row(8'd255, 8'd255, 8'hff, 8'h00, 8'ha5));
        // repeat sends an exact zero to 1.0, i.e. the far corner
        script.push_back(probe_row(24'h000000, 24'h000000, 1'b1, 24'ha500ff));
        script.push_back(load_row(8'd0, 8'd0, 8'h00, 8'hff, 8'h5a));
        // exact integers, positive and negative, also land on the far corner
        script.push_back(probe_row(24'h7f0000, 24'h810000, 1'b1, 24'ha500ff));
        script.push_back(cfg_row(CFG_WRAP, {30'd0, WRAP_CLAMP}));
        script.push_back(probe_row(24'h800000, 24'h800000, 1'b1, 24'h5aff00));
        script.push_back(probe_row(24'h7fffff, 24'h7fffff, 1'b1, 24'ha500ff));
        script.push_back(cfg_row(CFG_WRAP, {30'd0, WRAP_ZERO}));
        // just past 1.0 and just below 0.0 both go to zero
        script.push_back(probe_row(24'h010001, 24'hffffff, 1'b1, 24'h5aff00));
        script.push_back(probe_row(24'h010000, 24'h010000, 1'b1, 24'ha500ff));
        script.push_back(cfg_row(CFG_WRAP, {30'd0, WRAP_SPARE}));
        script.push_back(probe_row(24'h7fffff, 24'h000000, 1'b1, 24'h5aff00));
        // zero width acts as one, oversize height acts as the store size; grey output
        script.push_back(cfg_row(CFG_WRAP, {30'd0, WRAP_REPEAT}));
        script.push_back(cfg_row(CFG_WIDTH, 32'd0));
        script.push_back(cfg_row(CFG_HEIGHT, 32'd511));
        script.push_back(cfg_row(CFG_CHAN, {30'd0, CH_GREY}));
        script.push_back(probe_row(24'h008000, 24'h000000, 1'b0, '0));
        script.push_back(probe_row(24'hffc000, 24'h004000, 1'b0, '0));
        // 2 x 2 bilinear; an all-white blend must stay at 255
        script.push_back(cfg_row(CFG_FILTER, {31'd0, FILT_BILINEAR}));
        script.push_back(cfg_row(CFG_WIDTH, 32'd2));
        script.push_back(cfg_row(CFG_HEIGHT, 32'd2));
        script.push_back(cfg_row(CFG_CHAN, {30'd0, CH_RGB}));
        script.push_back(cfg_row(CFG_WRAP, {30'd0, WRAP_CLAMP}));
        script.push_back(load_row(8'd0, 8'd0, 8'hff, 8'hff, 8'hff));
        script.push_back(load_row(8'd1, 8'd0, 8'hff, 8'hff, 8'hff));
        script.push_back(load_row(8'd0, 8'd1, 8'hff, 8'hff, 8'hff));
        script.push_back(load_row(8'd1, 8'd1, 8'hff, 8'hff, 8'hff));
        script.push_back(probe_row(24'h008000, 24'h004000, 1'b1, 24'hffffff));
        script.push_back(load_row(8'd1, 8'd1, 8'h00, 8'h00, 8'h00));
        script.push_back(probe_row(24'h008000, 24'h008000, 1'b0, '0));
        // zero fractions on both axes make all four corners the same texel
        script.push_back(probe_row(24'h010000, 24'h000000, 1'b0, '0));
        // channel codes 0 and 2 behave as rgb
        script.push_back(cfg_row(CFG_CHAN, {30'd0, CH_CODE0}));
        script.push_back(probe_row(24'h003000, 24'h00c000, 1'b0, '0));
        script.push_back(cfg_row(CFG_CHAN, {30'd0, CH_CODE2}));
        script.push_back(probe_row(24'hffffff, 24'h00ffff, 1'b0, '0));

        // Hold reset, then release it at a falling edge.
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[i]) begin
            case (script[i].kind)
                ROW_CFG: begin
                    settle_block();
                    write_reg(script[i].reg_idx, script[i].value);
                end
                ROW_LOAD: begin
                    send_word(FUNC_LOAD, script[i].word, 1'b0, '0);
                end
                default: begin
                    fill_corners(script[i].word.u, script[i].word.v);
                    send_word(FUNC_SAMPLE, script[i].word, script[i].typed, script[i].rgb);
                end
            endcase
        end

        // Random part: four idling phases, three register settings each.
        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            settle_block();
            phase = seg / 3;
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 70;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 70;
                end
                default: begin
                    send_idle_pct  = 14;
                    recv_stall_pct = 14;
                end
            endcase

            // Force the size extremes on a few segments, pick the rest at random.
            if (seg == 0) begin
                dim_w = 9'd1;
                dim_h = 9'd1;
            end else if (seg == 4) begin
                dim_w = 9'd256;
                dim_h = 9'd256;
            end else if (seg == 7) begin
                dim_w = 9'd256;
                dim_h = 9'd1;
            end else begin
                dim_w = pick_dim();
                dim_h = pick_dim();
            end
            // Upper bits of each write are noise; only the field bits matter.
            write_reg(CFG_WRAP,   {30'($urandom), 2'($urandom_range(3, 0))});
            write_reg(CFG_FILTER, {31'($urandom), 1'(seg % 2)});
            write_reg(CFG_WIDTH,  {23'($urandom), dim_w});
            write_reg(CFG_HEIGHT, {23'($urandom), dim_h});
            write_reg(CFG_CHAN,   {30'($urandom), 2'($urandom_range(3, 0))});

            seg_start = items_sent;
            while (items_sent - seg_start < SEG_ITEMS) begin
                w = random_word();
                if ($urandom_range(99, 0) < 30) begin
                    // half the loads land inside the active texture so samples see fresh data
                    if ($urandom_range(1, 0) == 1) begin
                        w.x = 8'($urandom_range(int'(eff_dim(width_q)) - 1, 0));
                        w.y = 8'($urandom_range(int'(eff_dim(height_q)) - 1, 0));
                    end
                    send_word(FUNC_LOAD, w, 1'b0, '0);
                end else begin
                    w.u = rand_coord();
                    w.v = rand_coord();
                    fill_corners(w.u, w.v);
                    send_word(FUNC_SAMPLE, w, 1'b0, '0);
                end
            end
        end

        settle_block();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
